### sv/sdet_pkg.sv
// Package: signature ROM, result type and shared constants for the signature detector.
`timescale 1ns / 1ps

package sdet_pkg;

    localparam int unsigned NUM_SIGS       = 19;
    localparam int unsigned ID_W           = 5;
    localparam int unsigned HDR_ROM_BYTES  = 16;
    localparam int unsigned FTR_ROM_BYTES  = 8;
    localparam int unsigned DEF_MAX_HEADER = 16;
    localparam int unsigned DEF_MAX_FOOTER = 8;

    localparam int unsigned HDR_LEN [NUM_SIGS] = '{
        3, 8, 6, 6, 5, 4, 7, 6, 8, 3, 2, 8, 4, 2, 4, 4, 8, 2, 16
    };

    localparam logic [HDR_ROM_BYTES*8-1:0] HDR_ROM [NUM_SIGS] = '{
        128'hFFD8FF00_00000000_00000000_00000000,
        128'h89504E47_0D0A1A0A_00000000_00000000,
        128'h47494638_37610000_00000000_00000000,
        128'h47494638_39610000_00000000_00000000,
        128'h25504446_2D000000_00000000_00000000,
        128'h504B0304_00000000_00000000_00000000,
        128'h52617221_1A070000_00000000_00000000,
        128'h377ABCAF_271C0000_00000000_00000000,
        128'h504B0304_14000600_00000000_00000000,
        128'h49443300_00000000_00000000_00000000,
        128'hFFFB0000_00000000_00000000_00000000,
        128'h00000020_66747970_00000000_00000000,
        128'h52494646_00000000_00000000_00000000,
        128'h424D0000_00000000_00000000_00000000,
        128'h49492A00_00000000_00000000_00000000,
        128'h4D4D002A_00000000_00000000_00000000,
        128'hD0CF11E0_A1B11AE1_00000000_00000000,
        128'h4D5A0000_00000000_00000000_00000000,
        128'h53514C69_74652066_6F726D61_74203300
    };

    localparam int unsigned FTR_LEN [NUM_SIGS] = '{
        2, 8, 2, 2, 5, 4, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0
    };

    localparam logic [FTR_ROM_BYTES*8-1:0] FTR_ROM [NUM_SIGS] = '{
        64'hFFD90000_00000000,
        64'h49454E44_AE426082,
        64'h003B0000_00000000,
        64'h003B0000_00000000,
        64'h2525454F_46000000,
        64'h504B0506_00000000,
        64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0,
        64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0
    };

    typedef struct packed {
        logic            header_found;
        logic [ID_W-1:0] signature_id;
        logic            footer_found;
    } t_result;

    function automatic logic [7:0] hdr_byte(input int unsigned s, input int unsigned k);
        logic [7:0] b;
        b = 8'h00;
        if (k < HDR_ROM_BYTES) begin
            b = HDR_ROM[s][(HDR_ROM_BYTES - 1 - k) * 8 +: 8];
        end
        return b;
    endfunction

    function automatic logic [7:0] ftr_byte(input int unsigned s, input int unsigned k);
        logic [7:0] b;
        b = 8'h00;
        if (k < FTR_ROM_BYTES) begin
            b = FTR_ROM[s][(FTR_ROM_BYTES - 1 - k) * 8 +: 8];
        end
        return b;
    endfunction

endpackage

### sv/sdet_if.sv
// Interfaces: byte input channel and result output channel.
`timescale 1ns / 1ps

interface sdet_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source(output valid, output data_byte, output last_byte, input ready);
    modport sink(input valid, input data_byte, input last_byte, output ready);
endinterface

interface sdet_out_if;
    logic                       valid;
    logic                       ready;
    logic                       header_found;
    logic [sdet_pkg::ID_W-1:0]  signature_id;
    logic                       footer_found;

    modport source(output valid, output header_found, output signature_id,
                   output footer_found, input ready);
    modport sink(input valid, input header_found, input signature_id,
                 input footer_found, output ready);
endinterface

### sv/sdet_pcell.sv
// Prefix cell: holds per-signature match bits for one header byte position.
`timescale 1ns / 1ps

module sdet_pcell #(
    parameter int unsigned IDX = 0
) (
    input  logic                          i_clk,
    input  logic                          i_wr,
    input  logic [7:0]                    i_byte,
    output logic [sdet_pkg::NUM_SIGS-1:0] o_match
);

    logic [sdet_pkg::NUM_SIGS-1:0] r_match;
    logic [sdet_pkg::NUM_SIGS-1:0] n_match;

    always_comb begin
        for (int unsigned s = 0; s < sdet_pkg::NUM_SIGS; s++) begin
            if (IDX >= sdet_pkg::HDR_LEN[s]) begin
                n_match[s] = 1'b1;
            end else begin
                n_match[s] = (i_byte == sdet_pkg::hdr_byte(s, IDX));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_match <= n_match;
        end
    end

    assign o_match = r_match;

endmodule

### sv/sdet_tcell.sv
// Tail cell: one stage of the shift window over the last bytes.
`timescale 1ns / 1ps

module sdet_tcell (
    input  logic       i_clk,
    input  logic       i_shift,
    input  logic [7:0] i_byte,
    output logic [7:0] o_byte
);

    logic [7:0] r_byte;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_byte <= i_byte;
        end
    end

    assign o_byte = r_byte;

endmodule

### sv/sdet_eval.sv
// Evaluator: combines cell match bits and tail bytes into the first-match result.
`timescale 1ns / 1ps

module sdet_eval #(
    parameter int unsigned MAX_HEADER_LEN = sdet_pkg::DEF_MAX_HEADER,
    parameter int unsigned MAX_FOOTER_LEN = sdet_pkg::DEF_MAX_FOOTER,
    parameter int unsigned CW             = $clog2(MAX_HEADER_LEN + 1)
) (
    input  logic [sdet_pkg::NUM_SIGS-1:0] i_hvec [MAX_HEADER_LEN],
    input  logic [7:0]                    i_tail [MAX_FOOTER_LEN],
    input  logic [CW-1:0]                 i_cnt,
    output sdet_pkg::t_result             o_res
);

    logic [sdet_pkg::NUM_SIGS-1:0] hit;
    logic [sdet_pkg::NUM_SIGS-1:0] fhit;

    always_comb begin
        for (int unsigned s = 0; s < sdet_pkg::NUM_SIGS; s++) begin
            hit[s] = ({1'b0, i_cnt} >= (CW+1)'(sdet_pkg::HDR_LEN[s]));
            for (int unsigned k = 0; k < MAX_HEADER_LEN; k++) begin
                if (k < sdet_pkg::HDR_LEN[s]) begin
                    hit[s] = hit[s] & i_hvec[k][s];
                end
            end
            fhit[s] = (sdet_pkg::FTR_LEN[s] != 0)
                   && ({1'b0, i_cnt} >= (CW+1)'(sdet_pkg::FTR_LEN[s]));
            for (int unsigned i = 0; i < sdet_pkg::FTR_ROM_BYTES; i++) begin
                if (i < sdet_pkg::FTR_LEN[s]) begin
                    fhit[s] = fhit[s] & (i_tail[i] ==
                              sdet_pkg::ftr_byte(s, sdet_pkg::FTR_LEN[s] - 1 - i));
                end
            end
        end
    end

    always_comb begin
        o_res = '0;
        for (int s = sdet_pkg::NUM_SIGS - 1; s >= 0; s--) begin
            if (hit[s]) begin
                o_res.header_found = 1'b1;
                o_res.signature_id = sdet_pkg::ID_W'(s);
                o_res.footer_found = fhit[s];
            end
        end
    end

endmodule

### sv/file_signature_detector.sv
// Top level: file signature detector built from prefix and tail cell chains.
// A last byte sets a pending flag; the result then enters the output register when free.
// One byte per cycle unless stalled; a new buffer may start right after a last byte.
// Input stalls only while a result waits and the output register is full and not taken.
// Reset clears the byte count and the pending and output valid flags;
// cell contents are not reset.
`timescale 1ns / 1ps

module file_signature_detector #(
    parameter int unsigned MAX_HEADER_LEN = sdet_pkg::DEF_MAX_HEADER,
    parameter int unsigned MAX_FOOTER_LEN = sdet_pkg::DEF_MAX_FOOTER
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sdet_in_if.sink     i_in,
    sdet_out_if.source  o_out
);

    localparam int unsigned CW = $clog2(MAX_HEADER_LEN + 1);

    logic [CW-1:0]                 r_cnt;
    logic [CW-1:0]                 n_cnt;
    logic [CW-1:0]                 r_fin_cnt;
    logic                          r_eval_vld;
    logic                          r_out_vld;
    sdet_pkg::t_result             r_out;
    sdet_pkg::t_result             eval_res;
    logic                          in_acc;
    logic                          out_free;
    logic                          eval_fire;
    logic [sdet_pkg::NUM_SIGS-1:0] hvec [MAX_HEADER_LEN];
    logic [7:0]                    tail [MAX_FOOTER_LEN];

    assign out_free   = !r_out_vld || o_out.ready;
    assign eval_fire  = r_eval_vld && out_free;
    assign i_in.ready = !r_eval_vld || out_free;
    assign in_acc     = i_in.valid && i_in.ready;

    // advance the saturating count
    always_comb begin
        n_cnt = r_cnt;
        if (r_cnt < CW'(MAX_HEADER_LEN)) begin
            n_cnt = r_cnt + CW'(1);
        end
    end

    for (genvar k = 0; k < MAX_HEADER_LEN; k++) begin : g_pcell
        sdet_pcell #(
            .IDX(k)
        ) u_pcell (
            .i_clk  (i_clk),
            .i_wr   (in_acc && (r_cnt == CW'(k))),
            .i_byte (i_in.data_byte),
            .o_match(hvec[k])
        );
    end

    for (genvar i = 0; i < MAX_FOOTER_LEN; i++) begin : g_tcell
        if (i == 0) begin : g_head
            sdet_tcell u_tcell (
                .i_clk  (i_clk),
                .i_shift(in_acc),
                .i_byte (i_in.data_byte),
                .o_byte (tail[i])
            );
        end else begin : g_body
            sdet_tcell u_tcell (
                .i_clk  (i_clk),
                .i_shift(in_acc),
                .i_byte (tail[i-1]),
                .o_byte (tail[i])
            );
        end
    end

    sdet_eval #(
        .MAX_HEADER_LEN(MAX_HEADER_LEN),
        .MAX_FOOTER_LEN(MAX_FOOTER_LEN),
        .CW            (CW)
    ) u_eval (
        .i_hvec(hvec),
        .i_tail(tail),
        .i_cnt (r_fin_cnt),
        .o_res (eval_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt      <= '0;
            r_eval_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (in_acc) begin
                r_cnt <= i_in.last_byte ? '0 : n_cnt;
            end
            if (in_acc && i_in.last_byte) begin
                r_eval_vld <= 1'b1;
            end else if (eval_fire) begin
                r_eval_vld <= 1'b0;
            end
            if (eval_fire) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && i_in.last_byte) begin
            r_fin_cnt <= n_cnt;
        end
        if (eval_fire) begin
            r_out <= eval_res;
        end
    end

    assign o_out.valid        = r_out_vld;
    assign o_out.header_found = r_out.header_found;
    assign o_out.signature_id = r_out.signature_id;
    assign o_out.footer_found = r_out.footer_found;

endmodule
